[rtl/lwbc_pkg.sv]
// Shared types, constants and helpers of the layer window blend compositor.
// No dependencies; lwbc_blend and the top level import this package.
`timescale 1ns / 1ps

package lwbc_pkg;

    localparam int unsigned SCREEN_WIDTH  = 240;
    localparam int unsigned SCREEN_HEIGHT = 160;

    localparam int unsigned LAYER_COUNT = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned COEF_MAX   = 16;
    localparam int unsigned CHAN_MAX   = 31;

    typedef logic [14:0] t_colour;
    typedef logic [2:0]  t_layer;
    typedef logic [5:0]  t_winctl;

    localparam t_layer LAYER_SPRITE   = 3'd4;
    localparam t_layer LAYER_BACKDROP = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_ENABLES    = 3'd0,
        REG_BG_PRIORITIES      = 3'd1,
        REG_BLEND_SELECT       = 3'd2,
        REG_BLEND_COEFFICIENTS = 3'd3,
        REG_WINDOW_INSIDE      = 3'd4,
        REG_WINDOW_OUTSIDE     = 3'd5,
        REG_WINDOW0_BOUNDS     = 3'd6,
        REG_WINDOW1_BOUNDS     = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_ALPHA  = 2'd1,
        OP_BRIGHT = 2'd2,
        OP_DARK   = 2'd3
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_blend_ctl;

    function automatic logic in_rect(input logic [31:0] bounds, input logic [7:0] x,
                                     input logic [7:0] y, input logic [7:0] w,
                                     input logic [7:0] h);
        logic [7:0] l;
        logic [7:0] r;
        logic [7:0] t;
        logic [7:0] b;
        l = bounds[31:24];
        r = bounds[23:16];
        t = bounds[15:8];
        b = bounds[7:0];
        if (r > w || r < l) begin
            r = w;
        end
        if (b > h || b < t) begin
            b = h;
        end
        return (x >= l) && (x < r) && (y >= t) && (y < b);
    endfunction

    function automatic logic [4:0] clamp16(input logic [4:0] v);
        return (v > 5'(COEF_MAX)) ? 5'(COEF_MAX) : v;
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

endpackage

[rtl/lwbc_pix_if.sv]
// Input pixel channel: valid/ready handshake and the per-pixel layer payload.
// No dependencies.
`timescale 1ns / 1ps

interface lwbc_pix_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_line;
    logic [14:0] bg0_colour;
    logic [14:0] bg1_colour;
    logic [14:0] bg2_colour;
    logic [14:0] bg3_colour;
    logic [14:0] sprite_colour;
    logic [4:0]  layer_opaque;
    logic [1:0]  sprite_priority;
    logic        sprite_semi_transparent;
    logic        in_object_window;
    logic [14:0] backdrop_colour;

    modport source (
        output valid, pixel_x, pixel_line, bg0_colour, bg1_colour, bg2_colour, bg3_colour,
               sprite_colour, layer_opaque, sprite_priority, sprite_semi_transparent,
               in_object_window, backdrop_colour,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_line, bg0_colour, bg1_colour, bg2_colour, bg3_colour,
               sprite_colour, layer_opaque, sprite_priority, sprite_semi_transparent,
               in_object_window, backdrop_colour,
        output ready
    );
endinterface

[rtl/lwbc_rgb_if.sv]
// Output pixel channel: valid/ready handshake and the 24-bit RGB payload.
// No dependencies.
`timescale 1ns / 1ps

interface lwbc_rgb_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_rgb;

    modport source (output valid, pixel_rgb, input ready);
    modport sink (input valid, pixel_rgb, output ready);
endinterface

[rtl/lwbc_blend.sv]
// Colour effect back end: per-channel products, then sum, saturate and widen.
// Depends on lwbc_pkg.
`timescale 1ns / 1ps

module lwbc_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  lwbc_pkg::t_blend_ctl i_ctl,
    input  lwbc_pkg::t_colour   i_top,
    input  lwbc_pkg::t_colour   i_second,
    input  logic [14:0]         i_coefs,
    output logic                o_valid,
    output logic [23:0]         o_rgb
);
    import lwbc_pkg::*;

    logic [4:0] eva;
    logic [4:0] evb;
    logic [4:0] evy;
    logic [8:0] n_m0 [3];
    logic [8:0] n_m1 [3];
    logic [8:0] r_m0 [3];
    logic [8:0] r_m1 [3];
    t_colour    r_top;
    t_op        r_op;
    logic       r_valid;
    t_colour    res;
    logic       r_out_valid;
    logic [23:0] r_rgb;

    assign eva = clamp16(i_coefs[4:0]);
    assign evb = clamp16(i_coefs[9:5]);
    assign evy = clamp16(i_coefs[14:10]);

    always_comb begin
        logic [4:0] ca;
        logic [4:0] cb;
        for (int c = 0; c < 3; c++) begin
            ca = i_top[5*c +: 5];
            cb = i_second[5*c +: 5];
            case (i_ctl.op)
                OP_ALPHA: begin
                    n_m0[c] = {4'd0, ca} * {4'd0, eva};
                    n_m1[c] = {4'd0, cb} * {4'd0, evb};
                end
                OP_BRIGHT: begin
                    n_m0[c] = {4'd0, 5'(CHAN_MAX) - ca} * {4'd0, evy};
                    n_m1[c] = '0;
                end
                OP_DARK: begin
                    n_m0[c] = {4'd0, ca} * {4'd0, evy};
                    n_m1[c] = '0;
                end
                default: begin
                    n_m0[c] = '0;
                    n_m1[c] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_ctl.valid;
        end
        if (i_advance) begin
            r_m0  <= n_m0;
            r_m1  <= n_m1;
            r_top <= i_top;
            r_op  <= i_ctl.op;
        end
    end

    always_comb begin
        logic [4:0] ct;
        logic [9:0] sum;
        for (int c = 0; c < 3; c++) begin
            ct  = r_top[5*c +: 5];
            sum = {1'b0, r_m0[c]} + {1'b0, r_m1[c]};
            case (r_op)
                OP_ALPHA:  res[5*c +: 5] = (sum[9:4] > 6'(CHAN_MAX)) ? 5'(CHAN_MAX) : sum[8:4];
                OP_BRIGHT: res[5*c +: 5] = ct + r_m0[c][8:4];
                OP_DARK:   res[5*c +: 5] = ct - r_m0[c][8:4];
                default:   res[5*c +: 5] = ct;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r_out_valid <= r_valid;
        end
        if (i_advance) begin
            r_rgb <= {widen5(res[14:10]), widen5(res[9:5]), widen5(res[4:0])};
        end
    end

    assign o_valid = r_out_valid;
    assign o_rgb   = r_rgb;

endmodule

[rtl/layer_window_blend_compositor_top.sv]
// Top level of the layer window blend compositor: config registers, window
// and layer-priority stages. Depends on lwbc_pkg, lwbc_pix_if, lwbc_rgb_if, lwbc_blend.
`timescale 1ns / 1ps

// Usage:
//   i_pix carries one screen pixel per beat: four background colours, the
//   front sprite colour, opacity bits, sprite priority and mode flags, and
//   the backdrop colour. o_rgb returns one 24-bit RGB beat per input beat,
//   in order. Registers are written through i_cfg_we/i_cfg_index/i_cfg_data
//   while no pixel is in flight.
//   Pipeline: window decode, layer priority pick, effect products, then
//   sum/saturate/widen into the output register, each stage registered.
//   One beat per cycle is sustained while o_rgb does not stall.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken; i_pix.ready follows that, so a stall on o_rgb
//   holds every stage in place and nothing is dropped or repeated.
//   Reset clears all stage valid bits and returns the registers to their
//   defaults (priorities all 3, everything else zero).

module layer_window_blend_compositor_top #(
    parameter int unsigned SCREEN_WIDTH  = lwbc_pkg::SCREEN_WIDTH,
    parameter int unsigned SCREEN_HEIGHT = lwbc_pkg::SCREEN_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    lwbc_pix_if.sink          i_pix,
    lwbc_rgb_if.source        o_rgb
);
    import lwbc_pkg::*;

    logic [7:0]  r_display_enables;
    logic [7:0]  r_bg_priorities;
    logic [13:0] r_blend_select;
    logic [14:0] r_blend_coefficients;
    logic [13:0] r_window_inside;
    logic [13:0] r_window_outside;
    logic [31:0] r_window0_bounds;
    logic [31:0] r_window1_bounds;

    logic        advance;
    logic        out_valid;

    t_winctl     n_ctl;
    logic        r1_valid;
    t_winctl     r1_ctl;
    t_colour     r1_col [LAYER_COUNT+1];
    logic [4:0]  r1_opaque;
    logic [1:0]  r1_sprio;
    logic        r1_semi;

    logic [4:0]  elig;
    logic [4:0]  key [LAYER_COUNT];
    logic [2:0]  rank [LAYER_COUNT];
    t_layer      l0;
    t_layer      l1;
    t_colour     n_top;
    t_colour     n_second;
    t_op         n_op;

    t_blend_ctl  r2_ctl;
    t_colour     r2_top;
    t_colour     r2_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enables    <= '0;
            r_bg_priorities      <= 8'hFF;
            r_blend_select       <= '0;
            r_blend_coefficients <= '0;
            r_window_inside      <= '0;
            r_window_outside     <= '0;
            r_window0_bounds     <= '0;
            r_window1_bounds     <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_DISPLAY_ENABLES:    r_display_enables    <= i_cfg_data[7:0];
                REG_BG_PRIORITIES:      r_bg_priorities      <= i_cfg_data[7:0];
                REG_BLEND_SELECT:       r_blend_select       <= i_cfg_data[13:0];
                REG_BLEND_COEFFICIENTS: r_blend_coefficients <= i_cfg_data[14:0];
                REG_WINDOW_INSIDE:      r_window_inside      <= i_cfg_data[13:0];
                REG_WINDOW_OUTSIDE:     r_window_outside     <= i_cfg_data[13:0];
                REG_WINDOW0_BOUNDS:     r_window0_bounds     <= i_cfg_data;
                REG_WINDOW1_BOUNDS:     r_window1_bounds     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance     = !out_valid || o_rgb.ready;
    assign i_pix.ready = advance;

    // window decode
    always_comb begin
        if (r_display_enables[7:5] == 3'b000) begin
            n_ctl = 6'h3F;
        end else if (r_display_enables[5]
                     && in_rect(r_window0_bounds, i_pix.pixel_x, i_pix.pixel_line,
                                8'(SCREEN_WIDTH), 8'(SCREEN_HEIGHT))) begin
            n_ctl = r_window_inside[5:0];
        end else if (r_display_enables[6]
                     && in_rect(r_window1_bounds, i_pix.pixel_x, i_pix.pixel_line,
                                8'(SCREEN_WIDTH), 8'(SCREEN_HEIGHT))) begin
            n_ctl = r_window_inside[13:8];
        end else if (r_display_enables[7] && r_display_enables[4] && i_pix.in_object_window) begin
            n_ctl = r_window_outside[13:8];
        end else begin
            n_ctl = r_window_outside[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (advance) begin
            r1_valid <= i_pix.valid;
        end
        if (advance) begin
            r1_ctl    <= n_ctl;
            r1_col[0] <= i_pix.bg0_colour;
            r1_col[1] <= i_pix.bg1_colour;
            r1_col[2] <= i_pix.bg2_colour;
            r1_col[3] <= i_pix.bg3_colour;
            r1_col[4] <= i_pix.sprite_colour;
            r1_col[5] <= i_pix.backdrop_colour;
            r1_opaque <= i_pix.layer_opaque;
            r1_sprio  <= i_pix.sprite_priority;
            r1_semi   <= i_pix.sprite_semi_transparent;
        end
    end

    // layer priority pick: rank each eligible layer by priority, then order
    always_comb begin
        logic t1;
        logic t2;
        for (int i = 0; i < LAYER_COUNT; i++) begin
            elig[i] = r1_opaque[i] & r_display_enables[i] & r1_ctl[i];
        end
        for (int i = 0; i < int'(LAYER_SPRITE); i++) begin
            key[i] = {r_bg_priorities[2*i +: 2], 3'(i + 1)};
        end
        key[LAYER_SPRITE] = {r1_sprio, 3'd0};
        for (int i = 0; i < LAYER_COUNT; i++) begin
            rank[i] = '0;
            for (int j = 0; j < LAYER_COUNT; j++) begin
                if (elig[j] && key[j] < key[i]) begin
                    rank[i] = rank[i] + 3'd1;
                end
            end
        end
        l0 = LAYER_BACKDROP;
        l1 = LAYER_BACKDROP;
        for (int i = 0; i < LAYER_COUNT; i++) begin
            if (elig[i] && rank[i] == 3'd0) begin
                l0 = 3'(i);
            end
            if (elig[i] && rank[i] == 3'd1) begin
                l1 = 3'(i);
            end
        end
        n_top    = r1_col[l0];
        n_second = r1_col[l1];
        n_op     = OP_NONE;
        t1       = r_blend_select[l0];
        t2       = r_blend_select[4'd8 + 4'(l1)];
        if (l0 != LAYER_BACKDROP && r1_ctl[5]) begin
            if (l0 == LAYER_SPRITE && r1_semi && t2) begin
                n_op = OP_ALPHA;
            end else if (t_op'(r_blend_select[7:6]) == OP_ALPHA && t1 && t2) begin
                n_op = OP_ALPHA;
            end else if (t_op'(r_blend_select[7:6]) == OP_BRIGHT && t1) begin
                n_op = OP_BRIGHT;
            end else if (t_op'(r_blend_select[7:6]) == OP_DARK && t1) begin
                n_op = OP_DARK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl.valid <= 1'b0;
        end else if (advance) begin
            r2_ctl.valid <= r1_valid;
        end
        if (advance) begin
            r2_ctl.op <= n_op;
            r2_top    <= n_top;
            r2_second <= n_second;
        end
    end

    lwbc_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_ctl     (r2_ctl),
        .i_top     (r2_top),
        .i_second  (r2_second),
        .i_coefs   (r_blend_coefficients),
        .o_valid   (out_valid),
        .o_rgb     (o_rgb.pixel_rgb)
    );

    assign o_rgb.valid = out_valid;

endmodule
